FILE: design/spi_nor_flash_command_sequencer_macros.svh
// Assertion macros for the checker file of the serial NOR flash sequencer.
// Depends on nothing; included by the checker file.
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SNFCS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("snfcs: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SNFCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("snfcs: next-cycle check failed");

`endif

FILE: design/snfcs_pkg.sv
// Package for the serial NOR flash command sequencer: field widths, codes and
// register indexes. Depends on nothing.
package snfcs_pkg;

   localparam int ADDR_W = 24;
   localparam int LEN_W = 25;
   localparam int BYTE_W = 8;
   localparam int OP_W = 3;
   localparam int ACT_W = 2;
   localparam int NUM_REGS = 8;
   localparam int REG_IDX_W = 3;

   // Input actions.
   localparam logic [ACT_W-1:0] ACT_COMMAND = 2'd0;
   localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_EXCHANGE = 2'd2;

   // Host command codes.
   localparam logic [OP_W-1:0] OP_READ_ID = 3'd0;
   localparam logic [OP_W-1:0] OP_READ = 3'd1;
   localparam logic [OP_W-1:0] OP_PROGRAM = 3'd2;
   localparam logic [OP_W-1:0] OP_SECTOR_ERASE = 3'd3;
   localparam logic [OP_W-1:0] OP_CHIP_ERASE = 3'd4;

   // Configuration register indexes.
   localparam logic [REG_IDX_W-1:0] REG_OP_READ_ID = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_OP_WRITE_ENABLE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_OP_READ_STATUS = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_OP_SECTOR_ERASE = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OP_READ = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_OP_PROGRAM = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_OP_CHIP_ERASE = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_FILLER = 3'd7;

   typedef logic [BYTE_W-1:0] byte_type;

   localparam byte_type REG_RESET [NUM_REGS] = '{
      8'h9F, 8'h06, 8'h05, 8'h20, 8'h03, 8'h02, 8'hC7, 8'hFF
   };

   // Bit of the flash status register that reads one while a write is in progress.
   localparam int STATUS_BUSY_BIT = 0;

   typedef struct packed {
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              frame_end;
      logic              read_valid;
      logic [BYTE_W-1:0] read_byte;
      logic              need_data;
      logic [ADDR_W-1:0] id_value;
      logic              done_res;
      logic              rejected;
   } rsp_type;

endpackage

FILE: design/snfcs_req_if.sv
// Request channel of the serial NOR flash sequencer: valid/ready plus one input item.
// Depends on snfcs_pkg.
interface snfcs_req_if;
   logic                             valid;
   logic                             ready;
   logic [snfcs_pkg::ACT_W-1:0]      action;
   logic [snfcs_pkg::OP_W-1:0]       op;
   logic [snfcs_pkg::ADDR_W-1:0]     address;
   logic [snfcs_pkg::LEN_W-1:0]      length;
   logic [snfcs_pkg::BYTE_W-1:0]     data_byte;
   logic [snfcs_pkg::BYTE_W-1:0]     rx_byte;

   modport source (output valid, action, op, address, length, data_byte, rx_byte,
                   input ready);
   modport sink (input valid, action, op, address, length, data_byte, rx_byte,
                 output ready);
endinterface

FILE: design/snfcs_rsp_if.sv
// Response channel of the serial NOR flash sequencer: valid/ready plus one result item.
// Depends on snfcs_pkg.
interface snfcs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             tx_valid;
   logic [snfcs_pkg::BYTE_W-1:0]     tx_byte;
   logic                             frame_end;
   logic                             read_valid;
   logic [snfcs_pkg::BYTE_W-1:0]     read_byte;
   logic                             need_data;
   logic [snfcs_pkg::ADDR_W-1:0]     id_value;
   logic                             done_res;
   logic                             rejected;

   modport source (output valid, tx_valid, tx_byte, frame_end, read_valid, read_byte,
                   need_data, id_value, done_res, rejected, input ready);
   modport sink (input valid, tx_valid, tx_byte, frame_end, read_valid, read_byte,
                 need_data, id_value, done_res, rejected, output ready);
endinterface

FILE: design/snfcs_csr_if.sv
// Configuration write channel of the serial NOR flash sequencer.
// Depends on snfcs_pkg.
interface snfcs_csr_if;
   logic                               valid;
   logic                               ready;
   logic [snfcs_pkg::REG_IDX_W-1:0]    index;
   logic [snfcs_pkg::BYTE_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: design/spi_nor_flash_command_sequencer.sv
// Serial NOR flash command sequencer: phase machine, page split and result register.
// Depends on snfcs_pkg and the snfcs_req_if, snfcs_rsp_if and snfcs_csr_if interfaces.
//
// Usage. The request channel carries three kinds of transfer: a host command (read ID,
// read, program, sector erase, chip erase), a host data byte for a program, and the
// acknowledge of a finished serial byte exchange with the byte shifted in. Each request
// transfer yields at most one response transfer on the response channel: a byte to shift
// out (with an end-of-frame flag), a byte read from the flash, a request for the next
// program byte, a done flag (with the ID value after a read ID) or a reject flag for a
// command that arrived while another command was still running.
// The response is registered: it is held in an output register, loaded at the edge of
// the request transfer. Throughput is one request per cycle; the request side stays
// ready while the output register is empty or is being emptied in the same cycle, so a
// response that waits for the receiver holds off the next request until it is taken.
// The offset of a program address inside its page is found by a three-stage reciprocal
// multiply; it is ready before the page size is first needed, which is at least four
// transfers after the command.
// The configuration port writes opcode registers and the filler byte; it is always
// ready and should be used only while no command is in flight.
// A synchronous reset returns the machine to idle, empties the output register and
// loads the default opcodes.
module spi_nor_flash_command_sequencer #(
   parameter int PAGE_BYTES = 256
) (
   input  logic         clock,
   input  logic         reset,
   snfcs_req_if.sink    req_chan,
   snfcs_rsp_if.source  rsp_chan,
   snfcs_csr_if.sink    csr_chan
);

   localparam int ADDR_W = snfcs_pkg::ADDR_W;
   localparam int LEN_W = snfcs_pkg::LEN_W;
   localparam int BYTE_W = snfcs_pkg::BYTE_W;
   localparam int OFF_W = $clog2(PAGE_BYTES);
   localparam int PAGE_W = $clog2(PAGE_BYTES + 1);
   // Reciprocal for an exact quotient of any 24-bit address by the page size.
   localparam int SHIFT = ADDR_W + OFF_W;
   localparam int RECIP_W = ADDR_W + 2;
   localparam int PROD_W = ADDR_W + RECIP_W;
   localparam int QUOT_W = PROD_W - SHIFT;
   localparam longint unsigned RECIP_WIDE =
      ((longint'(1) << SHIFT) + longint'(PAGE_BYTES) - longint'(1)) / longint'(PAGE_BYTES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_WIDE);
   localparam logic [ADDR_W-1:0] PAGE_ADDR = ADDR_W'(PAGE_BYTES);
   localparam logic [PAGE_W-1:0] PAGE_SIZE = PAGE_W'(PAGE_BYTES);
   localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(PAGE_BYTES - 1);

   // Phase codes.
   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_ID = 4'd1;
   localparam logic [3:0] PH_WREN = 4'd2;
   localparam logic [3:0] PH_PRE_CMD = 4'd3;
   localparam logic [3:0] PH_PRE_DATA = 4'd4;
   localparam logic [3:0] PH_HDR = 4'd5;
   localparam logic [3:0] PH_DATA_WAIT = 4'd6;
   localparam logic [3:0] PH_DATA_TX = 4'd7;
   localparam logic [3:0] PH_RDATA = 4'd8;
   localparam logic [3:0] PH_POST_CMD = 4'd9;
   localparam logic [3:0] PH_POST_DATA = 4'd10;

   logic [3:0]                 phase_ff, phase_in;
   logic [snfcs_pkg::OP_W-1:0] op_ff, op_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic [LEN_W-1:0]           left_ff, left_in;
   logic [PAGE_W-1:0]          page_ff, page_in;
   logic [1:0]                 hidx_ff, hidx_in;
   logic [ADDR_W-1:0]          id_ff, id_in;
   logic [OFF_W-1:0]           off_ff, off_in;
   logic [2:0]                 mvld_ff, mvld_in;
   logic [PROD_W-1:0]          prod1_ff;
   logic [ADDR_W-1:0]          prod2_ff;
   snfcs_pkg::byte_type        cfg_ff [snfcs_pkg::NUM_REGS];
   logic                       rsp_valid_ff, rsp_valid_in;
   snfcs_pkg::rsp_type         rsp_ff, res;

   logic                       accept;
   logic                       have;
   logic                       prog_start;
   logic [QUOT_W-1:0]          quot;
   logic [OFF_W-1:0]           init_off;
   logic [PAGE_W-1:0]          init_room;
   logic [PAGE_W-1:0]          init_page;
   logic [PAGE_W-1:0]          post_room;
   logic [PAGE_W-1:0]          post_page;

   snfcs_pkg::byte_type        filler;

   // Result that asks for one byte to be shifted out.
   function automatic snfcs_pkg::rsp_type tx_res(input snfcs_pkg::byte_type b,
                                                 input logic last);
      snfcs_pkg::rsp_type r;
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_byte = b;
      r.frame_end = last;
      return r;
   endfunction

   // Smaller of the bytes still to program and the room left in the page.
   function automatic logic [PAGE_W-1:0] page_min(input logic [LEN_W-1:0] left,
                                                  input logic [PAGE_W-1:0] room);
      logic [PAGE_W-1:0] r;
      r = room;
      if (left < LEN_W'(room)) begin
         r = left[PAGE_W-1:0];
      end
      return r;
   endfunction

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign filler = cfg_ff[snfcs_pkg::REG_FILLER];

   // Page offset of a new program address: quotient by reciprocal, then remainder.
   assign quot = prod1_ff[PROD_W-1:SHIFT];
   assign init_off = OFF_W'(addr_ff - prod2_ff);
   assign init_room = PAGE_SIZE - PAGE_W'(init_off);
   assign init_page = page_min(left_ff, init_room);
   // Next page of a program that continues, from the tracked offset.
   assign post_room = PAGE_SIZE - PAGE_W'(off_ff);
   assign post_page = page_min(left_ff, post_room);

   assign prog_start = accept && (req_chan.action == snfcs_pkg::ACT_COMMAND) &&
                       (phase_ff == PH_IDLE) && (req_chan.op == snfcs_pkg::OP_PROGRAM);
   assign mvld_in = {mvld_ff[1:0], prog_start};

   always_comb begin
      logic [ADDR_W-1:0] acc;
      logic [LEN_W-1:0]  left_dec;
      logic              empty;
      snfcs_pkg::byte_type abyte;

      phase_in = phase_ff;
      op_in = op_ff;
      addr_in = addr_ff;
      left_in = left_ff;
      page_in = page_ff;
      hidx_in = hidx_ff;
      id_in = id_ff;
      off_in = off_ff;
      res = '0;
      acc = {id_ff[ADDR_W-BYTE_W-1:0], req_chan.rx_byte};
      left_dec = left_ff - LEN_W'(1);
      empty = 1'b1;
      abyte = addr_ff[7:0];

      // The page offset pipeline lands while the header is still going out.
      if (mvld_ff[2]) begin
         page_in = init_page;
         off_in = init_off;
      end

      if (accept) begin
         unique case (req_chan.action)
            snfcs_pkg::ACT_COMMAND: begin
               if (phase_ff != PH_IDLE) begin
                  res.rejected = 1'b1;
               end else if (req_chan.op <= snfcs_pkg::OP_CHIP_ERASE) begin
                  op_in = req_chan.op;
                  addr_in = req_chan.address;
                  left_in = req_chan.length;
                  hidx_in = 2'd0;
                  page_in = '0;
                  unique case (req_chan.op)
                     snfcs_pkg::OP_READ_ID: begin
                        id_in = '0;
                        res = tx_res(cfg_ff[snfcs_pkg::REG_OP_READ_ID], 1'b0);
                        phase_in = PH_ID;
                     end
                     snfcs_pkg::OP_READ: begin
                        res = tx_res(cfg_ff[snfcs_pkg::REG_OP_READ], 1'b0);
                        phase_in = PH_HDR;
                     end
                     default: begin
                        res = tx_res(cfg_ff[snfcs_pkg::REG_OP_WRITE_ENABLE], 1'b1);
                        phase_in = PH_WREN;
                     end
                  endcase
               end
            end
            snfcs_pkg::ACT_WRITE: begin
               if (phase_ff == PH_DATA_WAIT) begin
                  res = tx_res(req_chan.data_byte, page_ff == PAGE_W'(1));
                  page_in = page_ff - PAGE_W'(1);
                  left_in = left_dec;
                  addr_in = addr_ff + ADDR_W'(1);
                  // The offset restarts at a page boundary and where the address wraps.
                  if ((addr_ff == '1) || (off_ff == OFF_LAST)) begin
                     off_in = '0;
                  end else begin
                     off_in = off_ff + OFF_W'(1);
                  end
                  phase_in = PH_DATA_TX;
               end
            end
            snfcs_pkg::ACT_EXCHANGE: begin
               unique case (phase_ff)
                  PH_ID: begin
                     if (hidx_ff == 2'd0) begin
                        res = tx_res(filler, 1'b0);
                        hidx_in = 2'd1;
                     end else begin
                        id_in = acc;
                        if (hidx_ff == 2'd3) begin
                           res.id_value = acc;
                           res.done_res = 1'b1;
                           phase_in = PH_IDLE;
                        end else begin
                           res = tx_res(filler, hidx_ff == 2'd2);
                           hidx_in = hidx_ff + 2'd1;
                        end
                     end
                  end
                  PH_WREN: begin
                     if (op_ff == snfcs_pkg::OP_PROGRAM) begin
                        res = tx_res(cfg_ff[snfcs_pkg::REG_OP_PROGRAM], 1'b0);
                        hidx_in = 2'd0;
                        phase_in = PH_HDR;
                     end else begin
                        res = tx_res(cfg_ff[snfcs_pkg::REG_OP_READ_STATUS], 1'b0);
                        phase_in = PH_PRE_CMD;
                     end
                  end
                  PH_PRE_CMD: begin
                     res = tx_res(filler, 1'b1);
                     phase_in = PH_PRE_DATA;
                  end
                  PH_POST_CMD: begin
                     res = tx_res(filler, 1'b1);
                     phase_in = PH_POST_DATA;
                  end
                  PH_PRE_DATA: begin
                     if (req_chan.rx_byte[snfcs_pkg::STATUS_BUSY_BIT]) begin
                        res = tx_res(cfg_ff[snfcs_pkg::REG_OP_READ_STATUS], 1'b0);
                        phase_in = PH_PRE_CMD;
                     end else if (op_ff == snfcs_pkg::OP_CHIP_ERASE) begin
                        res = tx_res(cfg_ff[snfcs_pkg::REG_OP_CHIP_ERASE], 1'b1);
                        hidx_in = 2'd0;
                        phase_in = PH_HDR;
                     end else begin
                        res = tx_res(cfg_ff[snfcs_pkg::REG_OP_SECTOR_ERASE], 1'b0);
                        hidx_in = 2'd0;
                        phase_in = PH_HDR;
                     end
                  end
                  PH_HDR: begin
                     if (op_ff == snfcs_pkg::OP_CHIP_ERASE) begin
                        res = tx_res(cfg_ff[snfcs_pkg::REG_OP_READ_STATUS], 1'b0);
                        phase_in = PH_POST_CMD;
                     end else if (hidx_ff != 2'd3) begin
                        // Address bytes go out most significant first.
                        unique case (hidx_ff)
                           2'd0: abyte = addr_ff[23:16];
                           2'd1: abyte = addr_ff[15:8];
                           default: abyte = addr_ff[7:0];
                        endcase
                        if (op_ff == snfcs_pkg::OP_READ) begin
                           empty = (left_ff == '0);
                        end else if (op_ff == snfcs_pkg::OP_PROGRAM) begin
                           empty = (page_ff == '0);
                        end
                        res = tx_res(abyte, (hidx_ff == 2'd2) && empty);
                        hidx_in = hidx_ff + 2'd1;
                     end else if (op_ff == snfcs_pkg::OP_READ) begin
                        if (left_ff == '0) begin
                           res.done_res = 1'b1;
                           phase_in = PH_IDLE;
                        end else begin
                           res = tx_res(filler, left_ff == LEN_W'(1));
                           phase_in = PH_RDATA;
                        end
                     end else if ((op_ff == snfcs_pkg::OP_PROGRAM) && (page_ff != '0)) begin
                        res.need_data = 1'b1;
                        phase_in = PH_DATA_WAIT;
                     end else begin
                        res = tx_res(cfg_ff[snfcs_pkg::REG_OP_READ_STATUS], 1'b0);
                        phase_in = PH_POST_CMD;
                     end
                  end
                  PH_DATA_TX: begin
                     if (page_ff != '0) begin
                        res.need_data = 1'b1;
                        phase_in = PH_DATA_WAIT;
                     end else begin
                        res = tx_res(cfg_ff[snfcs_pkg::REG_OP_READ_STATUS], 1'b0);
                        phase_in = PH_POST_CMD;
                     end
                  end
                  PH_RDATA: begin
                     left_in = left_dec;
                     if (left_dec == '0) begin
                        res.done_res = 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        res = tx_res(filler, left_dec == LEN_W'(1));
                     end
                     res.read_valid = 1'b1;
                     res.read_byte = req_chan.rx_byte;
                  end
                  PH_POST_DATA: begin
                     if (req_chan.rx_byte[snfcs_pkg::STATUS_BUSY_BIT]) begin
                        res = tx_res(cfg_ff[snfcs_pkg::REG_OP_READ_STATUS], 1'b0);
                        phase_in = PH_POST_CMD;
                     end else if ((op_ff == snfcs_pkg::OP_PROGRAM) && (left_ff != '0)) begin
                        page_in = post_page;
                        res = tx_res(cfg_ff[snfcs_pkg::REG_OP_WRITE_ENABLE], 1'b1);
                        phase_in = PH_WREN;
                     end else begin
                        res.done_res = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                     // Idle or waiting for host data: no byte is outstanding.
                  end
               endcase
            end
            default: begin
               // Unused action code.
            end
         endcase
      end
   end

   // A request yields a response only if its result carries at least one of these flags.
   assign have = res.tx_valid || res.read_valid || res.need_data || res.done_res ||
                 res.rejected;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = have;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff <= '0;
         addr_ff <= '0;
         left_ff <= '0;
         page_ff <= '0;
         hidx_ff <= '0;
         id_ff <= '0;
         off_ff <= '0;
         mvld_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < snfcs_pkg::NUM_REGS; i++) begin
            cfg_ff[i] <= snfcs_pkg::REG_RESET[i];
         end
      end else begin
         phase_ff <= phase_in;
         op_ff <= op_in;
         addr_ff <= addr_in;
         left_ff <= left_in;
         page_ff <= page_in;
         hidx_ff <= hidx_in;
         id_ff <= id_in;
         off_ff <= off_in;
         mvld_ff <= mvld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            cfg_ff[csr_chan.index] <= csr_chan.data;
         end
      end
   end

   // Payload registers: the result and the page offset multiplier stages.
   always_ff @(posedge clock) begin
      if (accept && have) begin
         rsp_ff <= res;
      end
      if (mvld_ff[0]) begin
         prod1_ff <= PROD_W'(addr_ff) * PROD_W'(RECIP);
      end
      if (mvld_ff[1]) begin
         prod2_ff <= ADDR_W'(quot) * PAGE_ADDR;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.tx_valid = rsp_ff.tx_valid;
   assign rsp_chan.tx_byte = rsp_ff.tx_byte;
   assign rsp_chan.frame_end = rsp_ff.frame_end;
   assign rsp_chan.read_valid = rsp_ff.read_valid;
   assign rsp_chan.read_byte = rsp_ff.read_byte;
   assign rsp_chan.need_data = rsp_ff.need_data;
   assign rsp_chan.id_value = rsp_ff.id_value;
   assign rsp_chan.done_res = rsp_ff.done_res;
   assign rsp_chan.rejected = rsp_ff.rejected;

endmodule

FILE: design/snfcs_checker.sv
// Port-level checks for the serial NOR flash sequencer, bound to its top level.
// Depends on spi_nor_flash_command_sequencer_macros.svh and the top level's ports.
`include "spi_nor_flash_command_sequencer_macros.svh"

module snfcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        tx_valid,
   input logic [7:0]  tx_byte,
   input logic        frame_end,
   input logic        read_valid,
   input logic        need_data,
   input logic [23:0] id_value,
   input logic        done_res,
   input logic        rejected
);

   // A stalled response stays valid and keeps its byte and ID value until it is taken.
   `SNFCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(tx_byte) && $stable(id_value))

   // A reject carries nothing else.
   `SNFCS_ASSERT_SAME(a_reject_alone, clock, reset, rsp_valid && rejected, !tx_valid && !read_valid && !need_data && !done_res)

   // Chip select is only raised after a byte that is actually shifted.
   `SNFCS_ASSERT_SAME(a_end_with_tx, clock, reset, rsp_valid && frame_end, tx_valid)

   // The ID value shows only with a completion.
   `SNFCS_ASSERT_SAME(a_id_with_done, clock, reset, rsp_valid && !done_res, id_value == 24'd0)

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .tx_valid   (rsp_chan.tx_valid),
   .tx_byte    (rsp_chan.tx_byte),
   .frame_end  (rsp_chan.frame_end),
   .read_valid (rsp_chan.read_valid),
   .need_data  (rsp_chan.need_data),
   .id_value   (rsp_chan.id_value),
   .done_res   (rsp_chan.done_res),
   .rejected   (rsp_chan.rejected)
);

FILE: sim/spi_nor_flash_command_sequencer_test.sv
// Self-checking testbench for spi_nor_flash_command_sequencer: it plays host and serial
// engine, predicts every response transfer and compares it field by field.
// Depends on snfcs_pkg, the three channel interfaces and the sequencer RTL.
module spi_nor_flash_command_sequencer_test;
   import snfcs_pkg::*;

   localparam int PAGE_SIZE = 256;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEMS_PER_SETTING = 170;

   // Codes the block must ignore: the spare action and an op beyond chip erase.
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;

   // Sequencer phases as the predictor tracks them.
   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_ID, SEQ_WREN, SEQ_PRE_CMD, SEQ_PRE_DATA, SEQ_HDR,
      SEQ_DATA_WAIT, SEQ_DATA_TX, SEQ_RDATA, SEQ_POST_CMD, SEQ_POST_DATA
   } seq_phase_e;

   // One request transfer as the host and the serial engine present it.
   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] rx_byte;
   } flash_request_t;

   // Shadow of the command sequencer. Every accepted request advances the shadow state,
   // and the response it causes, if any, is queued until the block delivers it.
   class flash_sequencer_scoreboard;
      byte_type          opcode [NUM_REGS];
      seq_phase_e        phase;
      logic [OP_W-1:0]   cmd_op;
      logic [ADDR_W-1:0] flash_addr;
      logic [LEN_W-1:0]  bytes_left;
      logic [10:0]       page_left;
      logic [1:0]        hdr_idx;
      logic [ADDR_W-1:0] id_accum;
      rsp_type           outgoing;
      bit                outgoing_set;
      rsp_type           pending [$];
      int errors, checked, accepted, rejects, busy_polls;
      int cmd_count [5];

      function new();
         foreach (opcode[i]) opcode[i] = REG_RESET[i];
         phase = SEQ_IDLE;
         cmd_op = '0;
         flash_addr = '0;
         bytes_left = '0;
         page_left = '0;
         hdr_idx = '0;
         id_accum = '0;
         foreach (cmd_count[i]) cmd_count[i] = 0;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, byte_type value);
         opcode[idx] = value;
      endfunction

      function void shift_out(byte_type value, logic last);
         outgoing.tx_valid = 1'b1;
         outgoing.tx_byte = value;
         outgoing.frame_end = last;
         outgoing_set = 1'b1;
      endfunction

      function void complete();
         outgoing.done_res = 1'b1;
         outgoing_set = 1'b1;
         phase = SEQ_IDLE;
      endfunction

      function void want_data();
         outgoing.need_data = 1'b1;
         outgoing_set = 1'b1;
         phase = SEQ_DATA_WAIT;
      endfunction

      // Bytes of the current page: what is left of the transfer, up to the page end.
      function void load_page();
         int unsigned room;
         room = PAGE_SIZE - (flash_addr % PAGE_SIZE);
         page_left = (bytes_left < room) ? bytes_left : room;
      endfunction

      function void start_poll(bit before_erase);
         shift_out(opcode[REG_OP_READ_STATUS], 1'b0);
         phase = before_erase ? SEQ_PRE_CMD : SEQ_POST_CMD;
      endfunction

      function void header_step();
         int k;
         logic no_payload;
         logic [ADDR_W-1:0] shifted;
         if (cmd_op == OP_CHIP_ERASE) begin
            start_poll(1'b0);
         end else if (hdr_idx < 3) begin
            k = hdr_idx + 1;
            if (cmd_op == OP_READ) no_payload = (bytes_left == 0);
            else if (cmd_op == OP_PROGRAM) no_payload = (page_left == 0);
            else no_payload = 1'b1;
            shifted = flash_addr >> (8 * (3 - k));
            shift_out(shifted[BYTE_W-1:0], (k == 3) && no_payload);
            hdr_idx = k;
         end else if (cmd_op == OP_READ) begin
            if (bytes_left == 0) begin
               complete();
            end else begin
               shift_out(opcode[REG_FILLER], bytes_left == 1);
               phase = SEQ_RDATA;
            end
         end else if (cmd_op == OP_PROGRAM && page_left != 0) begin
            want_data();
         end else begin
            start_poll(1'b0);
         end
      endfunction

      function void exchange_done(byte_type rx);
         case (phase)
            SEQ_ID: begin
               if (hdr_idx == 0) begin
                  shift_out(opcode[REG_FILLER], 1'b0);
                  hdr_idx = 1;
               end else begin
                  id_accum = {id_accum[15:0], rx};
                  if (hdr_idx == 3) begin
                     outgoing.id_value = id_accum;
                     complete();
                  end else begin
                     shift_out(opcode[REG_FILLER], hdr_idx == 2);
                     hdr_idx = hdr_idx + 1;
                  end
               end
            end
            SEQ_WREN: begin
               if (cmd_op == OP_PROGRAM) begin
                  shift_out(opcode[REG_OP_PROGRAM], 1'b0);
                  hdr_idx = 0;
                  phase = SEQ_HDR;
               end else begin
                  start_poll(1'b1);
               end
            end
            SEQ_PRE_CMD, SEQ_POST_CMD: begin
               shift_out(opcode[REG_FILLER], 1'b1);
               phase = (phase == SEQ_PRE_CMD) ? SEQ_PRE_DATA : SEQ_POST_DATA;
            end
            SEQ_PRE_DATA: begin
               if (rx[STATUS_BUSY_BIT]) begin
                  busy_polls++;
                  start_poll(1'b1);
               end else if (cmd_op == OP_CHIP_ERASE) begin
                  shift_out(opcode[REG_OP_CHIP_ERASE], 1'b1);
                  hdr_idx = 0;
                  phase = SEQ_HDR;
               end else begin
                  shift_out(opcode[REG_OP_SECTOR_ERASE], 1'b0);
                  hdr_idx = 0;
                  phase = SEQ_HDR;
               end
            end
            SEQ_HDR: header_step();
            SEQ_DATA_TX: begin
               if (page_left != 0) want_data();
               else start_poll(1'b0);
            end
            SEQ_RDATA: begin
               outgoing.read_valid = 1'b1;
               outgoing.read_byte = rx;
               outgoing_set = 1'b1;
               bytes_left = bytes_left - 1'b1;
               if (bytes_left == 0) complete();
               else shift_out(opcode[REG_FILLER], bytes_left == 1);
            end
            SEQ_POST_DATA: begin
               if (rx[STATUS_BUSY_BIT]) begin
                  busy_polls++;
                  start_poll(1'b0);
               end else if (cmd_op == OP_PROGRAM && bytes_left != 0) begin
                  // Next page of the same program: a fresh write enable first.
                  load_page();
                  shift_out(opcode[REG_OP_WRITE_ENABLE], 1'b1);
                  phase = SEQ_WREN;
               end else begin
                  complete();
               end
            end
            default: ;
         endcase
      endfunction

      // Advances the shadow by one accepted request; returns whether it causes a response.
      function bit note_request(flash_request_t r);
         outgoing = '0;
         outgoing_set = 1'b0;
         accepted++;
         case (r.action)
            ACT_COMMAND: begin
               if (phase != SEQ_IDLE) begin
                  outgoing.rejected = 1'b1;
                  outgoing_set = 1'b1;
                  rejects++;
               end else if (r.op <= OP_CHIP_ERASE) begin
                  cmd_op = r.op;
                  flash_addr = r.address;
                  bytes_left = r.length;
                  hdr_idx = 0;
                  page_left = 0;
                  cmd_count[r.op]++;
                  case (r.op)
                     OP_READ_ID: begin
                        id_accum = '0;
                        shift_out(opcode[REG_OP_READ_ID], 1'b0);
                        phase = SEQ_ID;
                     end
                     OP_READ: begin
                        shift_out(opcode[REG_OP_READ], 1'b0);
                        phase = SEQ_HDR;
                     end
                     OP_PROGRAM: begin
                        load_page();
                        shift_out(opcode[REG_OP_WRITE_ENABLE], 1'b1);
                        phase = SEQ_WREN;
                     end
                     default: begin
                        shift_out(opcode[REG_OP_WRITE_ENABLE], 1'b1);
                        phase = SEQ_WREN;
                     end
                  endcase
               end
            end
            ACT_WRITE: begin
               if (phase == SEQ_DATA_WAIT) begin
                  shift_out(r.data_byte, page_left == 1);
                  page_left = page_left - 1'b1;
                  bytes_left = bytes_left - 1'b1;
                  flash_addr = flash_addr + 1'b1;
                  phase = SEQ_DATA_TX;
               end
            end
            ACT_EXCHANGE: exchange_done(r.rx_byte);
            default: ;
         endcase
         if (outgoing_set) pending.push_back(outgoing);
         return outgoing_set;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("response 0x%0h arrived with no response outstanding", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         compare_field("tx_valid", want.tx_valid, got.tx_valid);
         compare_field("tx_byte", want.tx_byte, got.tx_byte);
         compare_field("frame_end", want.frame_end, got.frame_end);
         compare_field("read_valid", want.read_valid, got.read_valid);
         compare_field("read_byte", want.read_byte, got.read_byte);
         compare_field("need_data", want.need_data, got.need_data);
         compare_field("id_value", want.id_value, got.id_value);
         compare_field("done_res", want.done_res, got.done_res);
         compare_field("rejected", want.rejected, got.rejected);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   snfcs_req_if req_chan ();
   snfcs_rsp_if rsp_chan ();
   snfcs_csr_if csr_chan ();

   spi_nor_flash_command_sequencer #(
      .PAGE_BYTES(PAGE_SIZE)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   flash_sequencer_scoreboard book = new();

   // Idling control. Percentages are the chance, per request or per cycle, that a burst
   // of idle cycles starts; the final stretch of the run turns idling off.
   int gap_pct = 0;
   int stall_pct = 0;
   bit no_idling = 1'b0;
   int results_caused = 0;
   int settings_used = 1;
   int quiet_cycles = 0;

   always #6 clock = ~clock;

   // Drives one request and waits for its transfer. The shadow is updated at the
   // transfer edge, so the next request can be chosen from the new phase at once.
   task automatic send_request(input flash_request_t r);
      int gap;
      if (!no_idling && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 15);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.action <= r.action;
      req_chan.op <= r.op;
      req_chan.address <= r.address;
      req_chan.length <= r.length;
      req_chan.data_byte <= r.data_byte;
      req_chan.rx_byte <= r.rx_byte;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (book.note_request(r)) results_caused++;
   endtask

   task automatic csr_transfer(input logic [REG_IDX_W-1:0] idx, input byte_type value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      book.write_reg(idx, value);
   endtask

   // Writes all eight registers back to back; valid stays high between the transfers.
   task automatic apply_opcodes(input byte_type read_id, input byte_type wren,
                                input byte_type status, input byte_type sector,
                                input byte_type rd, input byte_type prog,
                                input byte_type chip, input byte_type filler);
      csr_transfer(REG_OP_READ_ID, read_id);
      csr_transfer(REG_OP_WRITE_ENABLE, wren);
      csr_transfer(REG_OP_READ_STATUS, status);
      csr_transfer(REG_OP_SECTOR_ERASE, sector);
      csr_transfer(REG_OP_READ, rd);
      csr_transfer(REG_OP_PROGRAM, prog);
      csr_transfer(REG_OP_CHIP_ERASE, chip);
      csr_transfer(REG_FILLER, filler);
      csr_chan.valid <= 1'b0;
      settings_used++;
   endtask

   // Addresses lean toward page ends and the top of the array, where wrapping and
   // page splits happen.
   function automatic logic [ADDR_W-1:0] pick_address();
      logic [ADDR_W-1:0] a;
      a = $urandom;
      case ($urandom_range(0, 3))
         0: ;
         1: a[7:0] = 8'd255 - $urandom_range(0, 15);
         2: a = 24'hFFFFFF - $urandom_range(0, 300);
         default: a = $urandom_range(0, 1023);
      endcase
      return a;
   endfunction

   // Reads and programs stay short so the run stays bounded; the other commands ignore
   // the length, which lets every length bit, the top one too, be exercised there.
   function automatic logic [LEN_W-1:0] pick_length(logic [OP_W-1:0] op);
      if (op == OP_READ || op == OP_PROGRAM) begin
         if ($urandom_range(0, 4) == 0) return $urandom_range(13, 300);
         return $urandom_range(0, 12);
      end
      if ($urandom_range(0, 9) == 0) return 25'h1000000;
      return $urandom_range(0, 24'hFFFFFF);
   endfunction

   function automatic flash_request_t random_fields();
      flash_request_t r;
      r.action = ACT_COMMAND;
      r.op = $urandom_range(0, (1 << OP_W) - 1);
      r.address = pick_address();
      r.length = pick_length(OP_SECTOR_ERASE);
      r.data_byte = $urandom_range(0, 255);
      r.rx_byte = $urandom_range(0, 255);
      return r;
   endfunction

   function automatic flash_request_t random_command();
      flash_request_t r;
      int n;
      r = random_fields();
      n = $urandom_range(0, 99);
      if (n < 14) r.op = OP_READ_ID;
      else if (n < 38) r.op = OP_READ;
      else if (n < 68) r.op = OP_PROGRAM;
      else if (n < 80) r.op = OP_SECTOR_ERASE;
      else if (n < 92) r.op = OP_CHIP_ERASE;
      else r.op = $urandom_range(OP_CHIP_ERASE + 1, (1 << OP_W) - 1);
      r.length = pick_length(r.op);
      return r;
   endfunction

   // The request a well-behaved host and serial engine would send next: a command when
   // idle, a data byte when one is wanted, otherwise the acknowledge of the byte in
   // flight. Status reads come back busy about a third of the time.
   function automatic flash_request_t well_formed_item();
      flash_request_t r;
      r = random_fields();
      case (book.phase)
         SEQ_IDLE: r = random_command();
         SEQ_DATA_WAIT: r.action = ACT_WRITE;
         default: begin
            r.action = ACT_EXCHANGE;
            if (book.phase == SEQ_PRE_DATA || book.phase == SEQ_POST_DATA)
               r.rx_byte[STATUS_BUSY_BIT] = ($urandom_range(0, 2) == 0);
         end
      endcase
      return r;
   endfunction

   // Out-of-place traffic: any action in any phase, commands while busy included.
   function automatic flash_request_t noise_item();
      flash_request_t r;
      r = random_fields();
      r.action = $urandom_range(0, (1 << ACT_W) - 1);
      if (r.op == OP_READ || r.op == OP_PROGRAM) r.length = pick_length(r.op);
      return r;
   endfunction

   task automatic issue(input logic [ACT_W-1:0] action, input logic [OP_W-1:0] op,
                        input logic [ADDR_W-1:0] address, input logic [LEN_W-1:0] length);
      flash_request_t r;
      r = random_fields();
      r.action = action;
      r.op = op;
      r.address = address;
      r.length = length;
      send_request(r);
   endtask

   task automatic run_to_idle();
      while (book.phase != SEQ_IDLE) send_request(well_formed_item());
   endtask

   // Ends a stretch of traffic: the running command is completed, then every response
   // must drain before registers change.
   task automatic settle();
      run_to_idle();
      req_chan.valid <= 1'b0;
      while (book.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_traffic(input int items);
      int start;
      start = results_caused;
      while (results_caused - start < items) begin
         if ($urandom_range(0, 99) < 12) send_request(noise_item());
         else send_request(well_formed_item());
      end
      settle();
   endtask

   // The response side stalls in bursts, at a rate set per stretch of the run.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!no_idling && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 14);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Every response transfer is checked against the oldest outstanding prediction.
   always @(posedge clock) begin : response_monitor
      rsp_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.tx_valid = rsp_chan.tx_valid;
         got.tx_byte = rsp_chan.tx_byte;
         got.frame_end = rsp_chan.frame_end;
         got.read_valid = rsp_chan.read_valid;
         got.read_byte = rsp_chan.read_byte;
         got.need_data = rsp_chan.need_data;
         got.id_value = rsp_chan.id_value;
         got.done_res = rsp_chan.done_res;
         got.rejected = rsp_chan.rejected;
         book.check_result(got);
      end
   end

   // A hang shows up as a long run of cycles with no transfer on any channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("spi_nor_flash_command_sequencer regression: fail");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.action <= ACT_COMMAND;
      req_chan.op <= OP_READ_ID;
      req_chan.address <= '0;
      req_chan.length <= '0;
      req_chan.data_byte <= '0;
      req_chan.rx_byte <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= REG_OP_READ_ID;
      csr_chan.data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset opcodes. The stray transfers first: an acknowledge
      // and a data byte nobody asked for, the spare action code and an unknown op.
      gap_pct = 10;
      stall_pct = 10;
      issue(ACT_EXCHANGE, OP_READ_ID, '0, '0);
      issue(ACT_WRITE, OP_READ_ID, '0, '0);
      issue(ACT_UNUSED, OP_READ, 24'hFFFFFF, 25'h1FFFFFF);
      issue(ACT_COMMAND, OP_UNDEFINED, 24'hFFFFFF, 25'h1000000);
      issue(ACT_COMMAND, OP_READ_ID, '0, '0);
      run_to_idle();
      // A read of zero bytes ends the frame on the last address byte.
      issue(ACT_COMMAND, OP_READ, 24'hFFFFFF, '0);
      run_to_idle();
      issue(ACT_COMMAND, OP_READ, '0, 25'd1);
      run_to_idle();
      // A command while another runs is rejected, and a data byte outside a program
      // page is dropped.
      issue(ACT_COMMAND, OP_READ, 24'h123456, 25'd3);
      issue(ACT_COMMAND, OP_CHIP_ERASE, 24'hABCDEF, 25'h1000000);
      issue(ACT_WRITE, OP_READ_ID, '0, '0);
      run_to_idle();
      // An empty program still writes one page with no data bytes.
      issue(ACT_COMMAND, OP_PROGRAM, '0, '0);
      run_to_idle();
      // A program across the top of the array wraps to address zero and splits there;
      // an acknowledge while a data byte is wanted is ignored.
      issue(ACT_COMMAND, OP_PROGRAM, 24'hFFFFFE, 25'd3);
      while (book.phase != SEQ_DATA_WAIT) send_request(well_formed_item());
      issue(ACT_EXCHANGE, OP_READ_ID, '0, '0);
      run_to_idle();
      issue(ACT_COMMAND, OP_PROGRAM, 24'h0000F8, 25'd20);
      run_to_idle();
      issue(ACT_COMMAND, OP_SECTOR_ERASE, 24'hFFFFFF, 25'h1000000);
      run_to_idle();
      issue(ACT_COMMAND, OP_CHIP_ERASE, '0, '0);
      settle();

      // Random traffic under several opcode settings, idling patterns changing with
      // them. Every register goes through all zeros, all ones, random values and back
      // to its reset value; the final stretch runs with no idling on either side.
      apply_opcodes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      gap_pct = 20;
      stall_pct = 20;
      random_traffic(ITEMS_PER_SETTING);

      apply_opcodes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      gap_pct = 0;
      stall_pct = 0;
      random_traffic(ITEMS_PER_SETTING);

      apply_opcodes($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      gap_pct = 35;
      stall_pct = 35;
      random_traffic(ITEMS_PER_SETTING);

      apply_opcodes($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      gap_pct = 10;
      stall_pct = 30;
      random_traffic(ITEMS_PER_SETTING);

      apply_opcodes(REG_RESET[REG_OP_READ_ID], REG_RESET[REG_OP_WRITE_ENABLE],
                    REG_RESET[REG_OP_READ_STATUS], REG_RESET[REG_OP_SECTOR_ERASE],
                    REG_RESET[REG_OP_READ], REG_RESET[REG_OP_PROGRAM],
                    REG_RESET[REG_OP_CHIP_ERASE], REG_RESET[REG_FILLER]);
      no_idling = 1'b1;
      random_traffic(ITEMS_PER_SETTING);

      // settle() has already drained every response; the wait below lets the monitor catch
      // any response the block sends without a request behind it.
      repeat (5) @(posedge clock);
      if (book.pending.size() != 0) begin
         $error("%0d predicted responses never arrived", book.pending.size());
         book.errors++;
      end
      $display("Covered %0d requests, %0d of them answered, %0d responses checked, %0d %s",
               book.accepted, results_caused, book.checked, settings_used,
               "register settings.");
      $display("Commands: %0d read ID, %0d read, %0d program, %0d sector erase, %0d chip %s",
               book.cmd_count[OP_READ_ID], book.cmd_count[OP_READ],
               book.cmd_count[OP_PROGRAM], book.cmd_count[OP_SECTOR_ERASE],
               book.cmd_count[OP_CHIP_ERASE],
               $sformatf("erase; %0d rejected, %0d busy status reads.", book.rejects,
                         book.busy_polls));
      if (book.errors == 0)
         $display("spi_nor_flash_command_sequencer regression: pass");
      else
         $display("spi_nor_flash_command_sequencer regression: fail");
      $finish;
   end
endmodule
